>>> rtl/grmst_pkg.sv
// grmst_pkg: shared types and codes for the graph reach and spanning tree weight block
// depends on nothing; used by graph_reach_and_mst_weight_core
package grmst_pkg;

  // input command codes
  typedef enum logic [1:0] {
    CMD_EDGE = 2'd0,
    CMD_MARK = 2'd1,
    CMD_RUN  = 2'd2
  } cmd_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE2,
    ST_START,
    ST_JOIN,
    ST_SCAN,
    ST_COUNT,
    ST_FINISH
  } state_e;

  // one input transaction
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  node_a;
    logic [7:0]  node_b;
    logic [15:0] edge_weight;
    logic        edge_present;
    logic        node_excluded;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic [23:0] tree_weight;
    logic [8:0]  nodes_reached;
    logic        all_reached;
  } out_item_t;

endpackage

>>> rtl/grmst_ram.sv
// grmst_ram: generic single write port, single read port ram with registered read
// depends on nothing
module grmst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/graph_reach_and_mst_weight_core.sv
// Graph store with a minimum spanning tree walk (Prim) and a reachability check.
// After reset a clearing pass writes every adjacency entry absent and every exclusion
// mark zero, one entry a cycle over all 2**(2*ceil(log2(MAX_NODES))) entries (65536 at
// the default), and no input is taken meanwhile; configuration writes are taken as ever.
// An exclusion mark is written on acceptance, while an edge write passes through ST_EDGE2
// as well (the two symmetric entries go through the single adjacency write port). A run
// holds off input from its acceptance until its result is registered, including any wait
// for an earlier result still not taken: each joined node passes through ST_JOIN and then
// one pass over its adjacency row, one entry a cycle from the adjacency memory, during
// which the best link costs are read, updated and the next pick found; a final pipelined
// pass over the marks gives the reachability flag.
// Depends on grmst_pkg and grmst_ram.
module graph_reach_and_mst_weight_core #(
  parameter int MAX_NODES   = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [8:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  grmst_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output grmst_pkg::out_item_t out_data_o
);

  localparam int NIDX     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT      = $clog2(MAX_NODES + 1);
  localparam int ADJ_AW   = 2 * NIDX;
  localparam int ADJ_DEP  = 1 << ADJ_AW;
  localparam int EXCL_DEP = 1 << NIDX;
  localparam int WB       = WEIGHT_BITS;

  grmst_pkg::state_e state_q, state_d;

  logic [8:0]        node_count_q;
  logic [ADJ_AW-1:0] clr_q, clr_d;
  logic [CNT-1:0]    j_q, j_d;
  logic [NIDX-1:0]   jd_q, jd_d;
  logic              pv_q, pv_d;
  logic [NIDX-1:0]   u_q, u_d;
  logic [7:0]        start_q, start_d;
  logic [NIDX-1:0]   ea_q, ea_d, eb_q, eb_d;
  logic [WB:0]       edata_q, edata_d;
  logic [23:0]       sum_q, sum_d;
  logic [CNT-1:0]    reached_q, reached_d;
  logic              have_q, have_d;
  logic [WB-1:0]     min_q, min_d;
  logic [NIDX-1:0]   pick_q, pick_d;
  logic              all_q, all_d;
  logic [MAX_NODES-1:0] bval_q, bval_d;
  logic              out_valid_q, out_valid_d;
  grmst_pkg::out_item_t out_q, out_d;

  // memory ports
  logic              adj_we;
  logic [ADJ_AW-1:0] adj_waddr, adj_raddr;
  logic [WB:0]       adj_wdata, adj_rdata;
  logic              best_we;
  logic [NIDX-1:0]   best_waddr;
  logic [WB:0]       best_wdata, best_rdata;
  logic              excl_we, excl_wdata, excl_rdata;
  logic [NIDX-1:0]   excl_waddr, excl_raddr;

  // effective node count and input decode
  logic [31:0]       nc32;
  logic [CNT-1:0]    n_eff;
  logic [31:0]       w32;
  logic [WB-1:0]     w_in;
  logic              a_ok, b_ok, accept;
  logic [NIDX-1:0]   a_idx, b_idx, start_idx, j_idx;

  assign nc32  = 32'(node_count_q);
  assign n_eff = (nc32 == 32'd0) ? CNT'(1) :
                 (nc32 > 32'(MAX_NODES)) ? CNT'(MAX_NODES) : CNT'(nc32);
  assign w32   = 32'(in_data_i.edge_weight);
  assign w_in  = w32[WB-1:0];
  assign a_ok  = 32'(in_data_i.node_a) < 32'(MAX_NODES);
  assign b_ok  = 32'(in_data_i.node_b) < 32'(MAX_NODES);
  assign a_idx = NIDX'(in_data_i.node_a);
  assign b_idx = NIDX'(in_data_i.node_b);
  assign start_idx = NIDX'(start_q);
  assign j_idx = j_q[NIDX-1:0];

  assign in_ready_o = (state_q == grmst_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // exclusion marks: cleared by the reset pass, written by mark transactions,
  // read at the start node while idle and along the node index otherwise
  assign excl_we    = (state_q == grmst_pkg::ST_CLEAR) ||
                      (accept && (in_data_i.cmd == grmst_pkg::CMD_MARK) && a_ok);
  assign excl_waddr = (state_q == grmst_pkg::ST_CLEAR) ? clr_q[NIDX-1:0] : a_idx;
  assign excl_wdata = (state_q == grmst_pkg::ST_CLEAR) ? 1'b0 : in_data_i.node_excluded;
  assign excl_raddr = (state_q == grmst_pkg::ST_IDLE) ? a_idx : j_idx;

  // scan datapath: relax the link cost of one node and track the cheapest candidate
  // a best entry holds in-tree over cost and is only valid when its bval bit is set
  logic          s_it, s_ex, s_bv, s_upd, s_nvalid, s_cand, scan_done;
  logic [WB-1:0] s_w, s_cost, s_ncost;

  assign s_it     = bval_q[jd_q] && best_rdata[WB];
  assign s_bv     = bval_q[jd_q] && !best_rdata[WB];
  assign s_ex     = excl_rdata;
  assign s_cost   = best_rdata[WB-1:0];
  assign s_w      = adj_rdata[WB-1:0];
  assign s_upd    = !s_it && !s_ex && adj_rdata[WB] && (!s_bv || (s_w < s_cost));
  assign s_nvalid = s_bv || s_upd;
  assign s_ncost  = s_upd ? s_w : s_cost;
  assign s_cand   = !s_it && s_nvalid && (!have_q || (s_ncost < min_q));
  assign scan_done = (j_q == n_eff) && !pv_q;

  assign adj_raddr  = {u_q, j_idx};
  assign best_we    = (state_q == grmst_pkg::ST_JOIN) ||
                      ((state_q == grmst_pkg::ST_SCAN) && pv_q && s_upd);
  assign best_waddr = (state_q == grmst_pkg::ST_JOIN) ? u_q : jd_q;
  assign best_wdata = (state_q == grmst_pkg::ST_JOIN) ? {1'b1, {WB{1'b0}}} : {1'b0, s_w};

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    j_d         = j_q;
    jd_d        = jd_q;
    pv_d        = 1'b0;
    u_d         = u_q;
    start_d     = start_q;
    ea_d        = ea_q;
    eb_d        = eb_q;
    edata_d     = edata_q;
    sum_d       = sum_q;
    reached_d   = reached_q;
    have_d      = have_q;
    min_d       = min_q;
    pick_d      = pick_q;
    all_d       = all_q;
    bval_d      = bval_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    adj_we      = 1'b0;
    adj_waddr   = {ea_q, eb_q};
    adj_wdata   = edata_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      grmst_pkg::ST_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr_q;
        adj_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = grmst_pkg::ST_IDLE;
        end
      end
      grmst_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.cmd)
            grmst_pkg::CMD_EDGE: begin
              if (a_ok && b_ok) begin
                adj_we    = 1'b1;
                adj_waddr = {a_idx, b_idx};
                adj_wdata = in_data_i.edge_present ? {1'b1, w_in} : '0;
                ea_d      = b_idx;
                eb_d      = a_idx;
                edata_d   = adj_wdata;
                state_d   = grmst_pkg::ST_EDGE2;
              end
            end
            grmst_pkg::CMD_MARK: begin
              // the mark goes straight to the exclusion memory
            end
            grmst_pkg::CMD_RUN: begin
              bval_d    = '0;
              start_d   = in_data_i.node_a;
              sum_d     = '0;
              reached_d = '0;
              state_d   = grmst_pkg::ST_START;
            end
            default: begin
            end
          endcase
        end
      end
      grmst_pkg::ST_EDGE2: begin
        adj_we  = 1'b1;
        state_d = grmst_pkg::ST_IDLE;
      end
      grmst_pkg::ST_START: begin
        j_d   = '0;
        all_d = 1'b1;
        if ((32'(start_q) < 32'(n_eff)) && !excl_rdata) begin
          u_d       = start_idx;
          reached_d = CNT'(1);
          state_d   = grmst_pkg::ST_JOIN;
        end else begin
          state_d = grmst_pkg::ST_COUNT;
        end
      end
      grmst_pkg::ST_JOIN: begin
        bval_d[u_q] = 1'b1;
        j_d     = '0;
        have_d  = 1'b0;
        state_d = grmst_pkg::ST_SCAN;
      end
      grmst_pkg::ST_SCAN: begin
        // issue one row entry per cycle
        if (j_q < n_eff) begin
          j_d  = j_q + 1'b1;
          jd_d = j_idx;
          pv_d = 1'b1;
        end
        // process the entry read in the previous cycle
        if (pv_q) begin
          if (s_upd) begin
            bval_d[jd_q] = 1'b1;
          end
          if (s_cand) begin
            have_d = 1'b1;
            min_d  = s_ncost;
            pick_d = jd_q;
          end
        end
        if (scan_done) begin
          if (have_q) begin
            sum_d     = sum_q + 24'(min_q);
            reached_d = reached_q + 1'b1;
            u_d       = pick_q;
            state_d   = grmst_pkg::ST_JOIN;
          end else begin
            j_d     = '0;
            all_d   = 1'b1;
            state_d = grmst_pkg::ST_COUNT;
          end
        end
      end
      grmst_pkg::ST_COUNT: begin
        // issue one mark read per cycle, check it in the cycle after
        if (j_q < n_eff) begin
          j_d  = j_q + 1'b1;
          jd_d = j_idx;
          pv_d = 1'b1;
        end
        if (pv_q) begin
          if (!excl_rdata && !(bval_q[jd_q] && best_rdata[WB])) begin
            all_d = 1'b0;
          end
        end
        if ((j_q == n_eff) && !pv_q) begin
          state_d = grmst_pkg::ST_FINISH;
        end
      end
      grmst_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.tree_weight   = sum_q;
          out_d.nodes_reached = 9'(reached_q);
          out_d.all_reached   = all_q;
          state_d             = grmst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = grmst_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= grmst_pkg::ST_CLEAR;
      node_count_q <= 9'd256;
      clr_q        <= '0;
      j_q          <= '0;
      pv_q         <= 1'b0;
      have_q       <= 1'b0;
      reached_q    <= '0;
      bval_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      clr_q       <= clr_d;
      j_q         <= j_d;
      pv_q        <= pv_d;
      have_q      <= have_d;
      reached_q   <= reached_d;
      bval_q      <= bval_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    jd_q    <= jd_d;
    u_q     <= u_d;
    start_q <= start_d;
    ea_q    <= ea_d;
    eb_q    <= eb_d;
    edata_q <= edata_d;
    sum_q   <= sum_d;
    min_q   <= min_d;
    pick_q  <= pick_d;
    all_q   <= all_d;
    out_q   <= out_d;
  end

  // adjacency matrix: present bit over weight
  grmst_ram #(
    .Width (WB + 1),
    .Depth (ADJ_DEP)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  // in-tree flag over best link cost per node, guarded by bval_q
  grmst_ram #(
    .Width (WB + 1),
    .Depth (MAX_NODES)
  ) u_best_ram (
    .clk_i   (clk_i),
    .we_i    (best_we),
    .waddr_i (best_waddr),
    .wdata_i (best_wdata),
    .raddr_i (j_idx),
    .rdata_o (best_rdata)
  );

  // exclusion mark per node
  grmst_ram #(
    .Width (1),
    .Depth (EXCL_DEP)
  ) u_excl_ram (
    .clk_i   (clk_i),
    .we_i    (excl_we),
    .waddr_i (excl_waddr),
    .wdata_i (excl_wdata),
    .raddr_i (excl_raddr),
    .rdata_o (excl_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a pending read only exists inside a row scan or the final mark pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (state_q == grmst_pkg::ST_SCAN || state_q == grmst_pkg::ST_COUNT))
    else $error("read pending outside scan");

  // while the tree grows it never holds more nodes than are in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == grmst_pkg::ST_JOIN || state_q == grmst_pkg::ST_SCAN) |->
      (32'(reached_q) <= 32'(n_eff)))
    else $error("reached count exceeds nodes in use");

  // a picked node always carries a cost written in this run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == grmst_pkg::ST_SCAN && scan_done && have_q) |-> bval_q[pick_q])
    else $error("picked node without a link cost");

  // a finished run always leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == grmst_pkg::ST_FINISH && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("run result lost");
`endif

endmodule
